### design/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg
// shared widths, command codes and controller/datapath handshake types
// ----------------------------------------------------------------------------
package bdq_pkg;

	parameter int DEPTH_DEF = 16;
	parameter int DATA_W    = 32;
	parameter int CMD_W     = 3;
	parameter int CNT_W     = 5;

	parameter logic [CNT_W-1:0]  CAP_RESET  = 5'd16;
	parameter logic [DATA_W-1:0] EMPTY_WORD = 32'hFFFF_FFFF;

	typedef enum logic [CMD_W-1:0] {
		CMD_INS_FRONT = 3'd0,
		CMD_INS_REAR  = 3'd1,
		CMD_DEL_FRONT = 3'd2,
		CMD_DEL_REAR  = 3'd3,
		CMD_PEEK      = 3'd4
	} cmd_t;

	// controller to datapath
	typedef struct packed {
		logic latch;
		logic exec;
		logic rd;
		logic load;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;
	} dp_stat_t;

endpackage

### design/bdq_if.sv
// ----------------------------------------------------------------------------
// bdq channel interfaces
// command, response and capacity-write channels with valid/ready
// ----------------------------------------------------------------------------
interface bdq_in_if;
	logic                             valid;
	logic                             ready;
	logic [bdq_pkg::CMD_W-1:0]        cmd;
	logic signed [bdq_pkg::DATA_W-1:0] value;

	modport source (output valid, output cmd, output value, input ready);
	modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface bdq_out_if;
	logic                              valid;
	logic                              ready;
	logic                              ok;
	logic signed [bdq_pkg::DATA_W-1:0] front_item;
	logic signed [bdq_pkg::DATA_W-1:0] rear_item;
	logic                              is_empty;
	logic                              is_full;
	logic [bdq_pkg::CNT_W-1:0]         fill_level;

	modport source (output valid, output ok, output front_item, output rear_item,
		output is_empty, output is_full, output fill_level, input ready);
	modport sink   (input valid, input ok, input front_item, input rear_item,
		input is_empty, input is_full, input fill_level, output ready);
endinterface

interface bdq_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [bdq_pkg::CNT_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### design/bounded_deque_core.sv
// ----------------------------------------------------------------------------
// bounded_deque_core
// bounded double-ended queue of signed 32-bit words on a ring store
// ----------------------------------------------------------------------------
// each command beat (insert front/rear, delete front/rear, peek) yields one
// response beat with the success flag, front and rear words (-1 when empty),
// empty/full flags and the fill level after the command. in turn, the idle
// state takes the beat, the exec state updates head/count and writes the
// single store write port, the read state reads front and rear through the
// two registered read ports, and the done state loads the response register.
// the next command is taken the cycle after the load, while the previous
// response may still sit unclaimed in the response register; the sequencer
// only waits when a response is ready and the one before it has not been
// taken. writing the capacity register (always ready) also empties the deque;
// capacity 0 acts as 1, values above DEPTH act as DEPTH. store contents need
// no clearing: unread slots are never reported.
// ----------------------------------------------------------------------------
module bounded_deque_core #(
	parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	bdq_in_if.sink    cmd_ch,
	bdq_out_if.source rsp_ch,
	bdq_cfg_if.sink   cfg_ch
);

	bdq_pkg::dp_cmd_t  ctl;
	bdq_pkg::dp_stat_t sts;
	logic              cfg_we;

	// capacity writes are taken at any time
	assign cfg_ch.ready = 1'b1;
	assign cfg_we       = cfg_ch.valid;

	// sequencer
	bdq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd_ch.valid),
		.in_ready (cmd_ch.ready),
		.ctl      (ctl),
		.sts      (sts)
	);

	// ring store, pointers and response register
	bdq_datapath #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.sts       (sts),
		.in_cmd    (cmd_ch.cmd),
		.in_value  (cmd_ch.value),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_ch.data),
		.out_valid (rsp_ch.valid),
		.out_ready (rsp_ch.ready),
		.out_ok    (rsp_ch.ok),
		.out_front (rsp_ch.front_item),
		.out_rear  (rsp_ch.rear_item),
		.out_empty (rsp_ch.is_empty),
		.out_full  (rsp_ch.is_full),
		.out_level (rsp_ch.fill_level)
	);

endmodule

### design/bdq_ctrl.sv
// ----------------------------------------------------------------------------
// bdq_ctrl
// sequencer: accept, update, read, result load
// ----------------------------------------------------------------------------
module bdq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output bdq_pkg::dp_cmd_t  ctl,
	input  bdq_pkg::dp_stat_t sts
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_READ,
		S_DONE
	} state_t;

	state_t state_q;

	always_comb begin
		in_ready  = (state_q == S_IDLE);
		ctl.latch = in_valid && (state_q == S_IDLE);
		ctl.exec  = (state_q == S_EXEC);
		ctl.rd    = (state_q == S_READ);
		ctl.load  = (state_q == S_DONE) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_EXEC;
				end
				S_EXEC: begin
					state_q <= S_READ;
				end
				S_READ: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (sts.out_free) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### design/bdq_datapath.sv
// ----------------------------------------------------------------------------
// bdq_datapath
// ring store, head/count registers, capacity register and result register
// ----------------------------------------------------------------------------
module bdq_datapath #(
	parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  bdq_pkg::dp_cmd_t                  ctl,
	output bdq_pkg::dp_stat_t                 sts,
	input  logic [bdq_pkg::CMD_W-1:0]         in_cmd,
	input  logic signed [bdq_pkg::DATA_W-1:0] in_value,
	input  logic                              cfg_we,
	input  logic [bdq_pkg::CNT_W-1:0]         cfg_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              out_ok,
	output logic signed [bdq_pkg::DATA_W-1:0] out_front,
	output logic signed [bdq_pkg::DATA_W-1:0] out_rear,
	output logic                              out_empty,
	output logic                              out_full,
	output logic [bdq_pkg::CNT_W-1:0]         out_level
);

	localparam int CW      = bdq_pkg::CNT_W;
	localparam int DW      = bdq_pkg::DATA_W;
	localparam int CNT_TOP = (1 << CW) - 1;
	localparam int CAP_MAX = (DEPTH < CNT_TOP) ? DEPTH : CNT_TOP;
	localparam int HW      = (CAP_MAX > 1) ? $clog2(CAP_MAX) : 1;
	localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [CW-1:0] CAP_LIM = CW'(CAP_MAX);

	logic [DW-1:0] mem [DEPTH];

	logic [CW-1:0]              cap_raw_q;
	logic [CW-1:0]              cap_eff;
	logic [HW-1:0]              head_q;
	logic [CW-1:0]              count_q;
	logic [bdq_pkg::CMD_W-1:0]  cmd_q;
	logic [DW-1:0]              value_q;
	logic                       ok_q;
	logic [DW-1:0]              rd_front_q;
	logic [DW-1:0]              rd_rear_q;
	logic                       out_valid_q;

	logic [HW-1:0] head_n;
	logic [CW-1:0] count_n;
	logic          ok_n;
	logic          we;
	logic [HW-1:0] wslot;
	logic [HW-1:0] rear_slot;
	logic          full;
	logic          empty;

	// physical slot of logical position pos, wrapping at the capacity
	function automatic logic [HW-1:0] slot_of(input logic [HW-1:0] head,
		input logic [CW-1:0] pos, input logic [CW-1:0] cap);
		logic [CW:0] s;
		s = (CW+1)'(head) + (CW+1)'(pos);
		if (s >= (CW+1)'(cap)) s = s - (CW+1)'(cap);
		return HW'(s);
	endfunction

	// capacity saturated to 1..CAP_MAX
	always_comb begin
		if (cap_raw_q == '0) cap_eff = CW'(1);
		else if (cap_raw_q > CAP_LIM) cap_eff = CAP_LIM;
		else cap_eff = cap_raw_q;
	end

	assign full      = (count_q == cap_eff);
	assign empty     = (count_q == '0);
	assign rear_slot = slot_of(head_q, count_q - 1'b1, cap_eff);

	always_comb begin
		head_n  = head_q;
		count_n = count_q;
		ok_n    = 1'b0;
		we      = 1'b0;
		wslot   = head_q;
		case (cmd_q)
			bdq_pkg::CMD_INS_FRONT: begin
				if (!full) begin
					head_n  = (head_q == '0) ? HW'(cap_eff - 1'b1) : head_q - 1'b1;
					wslot   = head_n;
					we      = 1'b1;
					count_n = count_q + 1'b1;
					ok_n    = 1'b1;
				end
			end
			bdq_pkg::CMD_INS_REAR: begin
				if (!full) begin
					wslot   = slot_of(head_q, count_q, cap_eff);
					we      = 1'b1;
					count_n = count_q + 1'b1;
					ok_n    = 1'b1;
				end
			end
			bdq_pkg::CMD_DEL_FRONT: begin
				if (!empty) begin
					head_n  = slot_of(head_q, CW'(1), cap_eff);
					count_n = count_q - 1'b1;
					ok_n    = 1'b1;
				end
			end
			bdq_pkg::CMD_DEL_REAR: begin
				if (!empty) begin
					count_n = count_q - 1'b1;
					ok_n    = 1'b1;
				end
			end
			bdq_pkg::CMD_PEEK: begin
				ok_n = 1'b1;
			end
			default: begin
				ok_n = 1'b0;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_raw_q   <= bdq_pkg::CAP_RESET;
			head_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_raw_q <= cfg_data;
				head_q    <= '0;
				count_q   <= '0;
			end else if (ctl.exec) begin
				head_q  <= head_n;
				count_q <= count_n;
			end
			if (ctl.load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// payload registers and store
	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			cmd_q   <= in_cmd;
			value_q <= in_value;
		end
		if (ctl.exec) ok_q <= ok_n;
		if (ctl.exec && we) mem[AW'(wslot)] <= value_q;
		if (ctl.rd) begin
			rd_front_q <= mem[AW'(head_q)];
			rd_rear_q  <= mem[AW'(rear_slot)];
		end
		if (ctl.load) begin
			out_ok    <= ok_q;
			out_front <= empty ? bdq_pkg::EMPTY_WORD : rd_front_q;
			out_rear  <= empty ? bdq_pkg::EMPTY_WORD : rd_rear_q;
			out_empty <= empty;
			out_full  <= full;
			out_level <= count_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign sts.out_free = !out_valid_q || out_ready;

	a_count_in_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cap_eff)
		else $error("fill count above capacity");

	a_head_in_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(CW'(head_q) < cap_eff))
		else $error("head pointer outside ring");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load |-> (!out_valid_q || out_ready))
		else $error("result register overwritten before taken");

endmodule

### tb/sv/bounded_deque_core_tb.sv
// ----------------------------------------------------------------------------
// bounded_deque_core_tb
// self-checking bench for the bounded deque: a queue-fed command driver, a
// response monitor that checks every field against a ring-buffer predictor,
// and capacity rewrites between drained phases (including 0 and 31)
// ----------------------------------------------------------------------------
module bounded_deque_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CMD_W     = bdq_pkg::CMD_W;
	localparam int DATA_W    = bdq_pkg::DATA_W;
	localparam int CNT_W     = bdq_pkg::CNT_W;
	localparam int DEPTH_DEF = bdq_pkg::DEPTH_DEF;
	localparam int RING_AW   = (DEPTH_DEF > 1) ? $clog2(DEPTH_DEF) : 1;

	// command codes outside the enum, handled as a failing peek
	localparam logic [CMD_W-1:0] CMD_RSVD_LO = 3'd5;
	localparam logic [CMD_W-1:0] CMD_RSVD_HI = 3'd7;

	localparam int IDLE_PCT   = 9;     // sender gap chance per cycle
	localparam int STALL_PCT  = 9;     // receiver stall chance per cycle
	localparam int QUIET_MAX  = 5000;  // cycles with no beat before giving up
	localparam int PHASE_LEN  = 100;   // random commands per capacity setting
	localparam int TAIL_WAIT  = 8;     // settle time after the last response

	typedef struct packed {
		logic [CMD_W-1:0]         op;
		logic signed [DATA_W-1:0] word;
	} deque_req_t;

	typedef struct {
		logic                     ok;
		logic signed [DATA_W-1:0] front_item;
		logic signed [DATA_W-1:0] rear_item;
		logic                     is_empty;
		logic                     is_full;
		logic [CNT_W-1:0]         fill_level;
	} deque_view_t;

	logic clk = 1'b0;
	logic arst_n;

	bdq_in_if  cmd_ch();
	bdq_out_if rsp_ch();
	bdq_cfg_if cfg_ch();

	bounded_deque_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd_ch (cmd_ch),
		.rsp_ch (rsp_ch),
		.cfg_ch (cfg_ch)
	);

	always #1 clk = ~clk;

	// commands waiting to be sent, and responses the predictor expects
	deque_req_t  cmd_backlog[$];
	deque_view_t view_expected[$];
	deque_req_t  next_req;
	deque_view_t rsp_want;

	int n_queued  = 0;  // commands handed to the driver
	int n_checked = 0;  // response beats seen by the monitor
	int n_fail    = 0;
	int quiet_cycles = 0;
	logic steady = 1'b0;  // no gaps and no stalls while set

	// predictor copy of the deque
	logic signed [DATA_W-1:0] ring_words[DEPTH_DEF];
	logic [CNT_W-1:0]         ring_head;
	logic [CNT_W-1:0]         ring_count;
	logic [CNT_W-1:0]         cap_reg;

	// register value saturated to 1..DEPTH
	function automatic logic [CNT_W-1:0] usable_cap(input logic [CNT_W-1:0] raw);
		if (raw == 0)
			return CNT_W'(1);
		if (raw > DEPTH_DEF)
			return CNT_W'(DEPTH_DEF);
		return raw;
	endfunction

	// physical slot of logical position pos, wrapping at the capacity
	function automatic logic [CNT_W-1:0] ring_slot(input logic [CNT_W-1:0] pos,
		input logic [CNT_W-1:0] lim);
		logic [CNT_W:0] s;
		s = (CNT_W+1)'(ring_head) + (CNT_W+1)'(pos);
		if (s >= (CNT_W+1)'(lim))
			s = s - (CNT_W+1)'(lim);
		return s[CNT_W-1:0];
	endfunction

	// apply one accepted command and queue the view it should produce
	task automatic deque_apply(input logic [CMD_W-1:0] op,
		input logic signed [DATA_W-1:0] word);
		deque_view_t v;
		logic [CNT_W-1:0] lim;
		lim = usable_cap(cap_reg);
		v.ok = 1'b0;
		case (op)
			bdq_pkg::CMD_INS_FRONT: begin
				if (ring_count < lim) begin
					ring_head = (ring_head == 0) ? lim - 1'b1 : ring_head - 1'b1;
					ring_words[RING_AW'(ring_head)] = word;
					ring_count++;
					v.ok = 1'b1;
				end
			end
			bdq_pkg::CMD_INS_REAR: begin
				if (ring_count < lim) begin
					ring_words[RING_AW'(ring_slot(ring_count, lim))] = word;
					ring_count++;
					v.ok = 1'b1;
				end
			end
			bdq_pkg::CMD_DEL_FRONT: begin
				if (ring_count > 0) begin
					ring_head = ring_slot(CNT_W'(1), lim);
					ring_count--;
					v.ok = 1'b1;
				end
			end
			bdq_pkg::CMD_DEL_REAR: begin
				if (ring_count > 0) begin
					ring_count--;
					v.ok = 1'b1;
				end
			end
			bdq_pkg::CMD_PEEK: v.ok = 1'b1;
			default: v.ok = 1'b0;
		endcase
		if (ring_count == 0) begin
			v.front_item = bdq_pkg::EMPTY_WORD;
			v.rear_item  = bdq_pkg::EMPTY_WORD;
		end else begin
			v.front_item = ring_words[RING_AW'(ring_head)];
			v.rear_item  = ring_words[RING_AW'(ring_slot(ring_count - 1'b1, lim))];
		end
		v.is_empty   = (ring_count == 0);
		v.is_full    = (ring_count == lim);
		v.fill_level = ring_count;
		view_expected.push_back(v);
	endtask

	task automatic check_field(input string name, input logic [DATA_W-1:0] want,
		input logic [DATA_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %h, got %h", name, want, got);
			n_fail++;
		end
	endtask

	// ------------------------------------------------------------------------
	// command driver: predicts on each accepted beat, then offers the next
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
			cmd_ch.cmd   <= bdq_pkg::CMD_PEEK;
			cmd_ch.value <= '0;
		end else begin
			if (cmd_ch.valid && cmd_ch.ready)
				deque_apply(cmd_ch.cmd, cmd_ch.value);
			// a held beat stays put; otherwise load the next one or go idle
			if (!cmd_ch.valid || cmd_ch.ready) begin
				if (cmd_backlog.size() > 0 &&
						(steady || $urandom_range(99) >= IDLE_PCT)) begin
					next_req = cmd_backlog.pop_front();
					cmd_ch.cmd   <= next_req.op;
					cmd_ch.value <= next_req.word;
					cmd_ch.valid <= 1'b1;
				end else begin
					cmd_ch.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// response monitor: every beat against the oldest expected view
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				n_checked <= n_checked + 1;
				if (view_expected.size() == 0) begin
					$error("response beat with no command outstanding");
					n_fail++;
				end else begin
					rsp_want = view_expected.pop_front();
					check_field("ok", DATA_W'(rsp_want.ok), DATA_W'(rsp_ch.ok));
					check_field("front_item", rsp_want.front_item, rsp_ch.front_item);
					check_field("rear_item", rsp_want.rear_item, rsp_ch.rear_item);
					check_field("is_empty", DATA_W'(rsp_want.is_empty),
						DATA_W'(rsp_ch.is_empty));
					check_field("is_full", DATA_W'(rsp_want.is_full),
						DATA_W'(rsp_ch.is_full));
					check_field("fill_level", DATA_W'(rsp_want.fill_level),
						DATA_W'(rsp_ch.fill_level));
				end
			end
			rsp_ch.ready <= steady || ($urandom_range(99) >= STALL_PCT);
		end
	end

	// watchdog: too long without any beat on any channel
	always @(posedge clk) begin
		if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_MAX) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic send(input logic [CMD_W-1:0] op, input logic [DATA_W-1:0] word);
		deque_req_t r;
		r.op   = op;
		r.word = word;
		cmd_backlog.push_back(r);
		n_queued++;
	endtask

	// block until every queued command has been answered
	task automatic drain();
		while (n_checked < n_queued)
			@(posedge clk);
	endtask

	// capacity write, only called with the deque drained; it also empties it
	task automatic set_capacity(input logic [CNT_W-1:0] cap);
		@(posedge clk);
		cfg_ch.data  <= cap;
		cfg_ch.valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		cap_reg    = cap;
		ring_head  = '0;
		ring_count = '0;
	endtask

	// random data word, with the sign and magnitude extremes now and then
	function automatic logic [DATA_W-1:0] any_word();
		case ($urandom_range(15))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	// random commands in bursts that lean toward filling or toward emptying,
	// so full and empty are both reached and the head wraps at any capacity
	task automatic random_phase(input int n);
		int lean;
		int r;
		lean = 50;
		for (int i = 0; i < n; i++) begin
			if (i % 24 == 0)
				case ($urandom_range(2))
					0: lean = 85;
					1: lean = 50;
					default: lean = 15;
				endcase
			r = $urandom_range(99);
			if (r < 3)
				send(CMD_W'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI)), any_word());
			else if (r < 10)
				send(bdq_pkg::CMD_PEEK, any_word());
			else if ($urandom_range(99) < lean)
				send($urandom_range(1) ? bdq_pkg::CMD_INS_FRONT
					: bdq_pkg::CMD_INS_REAR, any_word());
			else
				send($urandom_range(1) ? bdq_pkg::CMD_DEL_FRONT
					: bdq_pkg::CMD_DEL_REAR, any_word());
		end
	endtask

	// capacity settings after the reset phase: the extremes, out-of-range
	// values on both sides, and a spread in between
	logic [CNT_W-1:0] cap_plan[] = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd17,
		5'd5, 5'd2, 5'd8, 5'd3, 5'd12};

	initial begin
		arst_n       = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.cmd   = bdq_pkg::CMD_PEEK;
		cmd_ch.value = '0;
		rsp_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data  = '0;
		cap_reg      = bdq_pkg::CAP_RESET;
		ring_head    = '0;
		ring_count   = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// reset capacity: empty-deque failures, reserved codes, extreme
		// words at both ends, then back down past empty
		send(bdq_pkg::CMD_PEEK, 32'h0);
		send(bdq_pkg::CMD_DEL_FRONT, 32'h0);
		send(bdq_pkg::CMD_DEL_REAR, 32'h0);
		send(CMD_RSVD_LO, 32'h0);
		send(bdq_pkg::CMD_INS_FRONT, 32'h7FFF_FFFF);
		send(bdq_pkg::CMD_INS_REAR, 32'h8000_0000);
		send(bdq_pkg::CMD_INS_FRONT, 32'hFFFF_FFFF);
		send(bdq_pkg::CMD_INS_REAR, 32'h0);
		send(bdq_pkg::CMD_PEEK, 32'h1234_5678);
		send(CMD_RSVD_HI, 32'h5A5A_5A5A);
		send(bdq_pkg::CMD_DEL_FRONT, 32'h0);
		send(bdq_pkg::CMD_DEL_REAR, 32'h0);
		send(bdq_pkg::CMD_DEL_FRONT, 32'h0);
		send(bdq_pkg::CMD_DEL_REAR, 32'h0);
		send(bdq_pkg::CMD_DEL_FRONT, 32'h0);
		random_phase(PHASE_LEN);
		// sender holds here until every response is back
		drain();

		foreach (cap_plan[p]) begin
			set_capacity(cap_plan[p]);
			if (p == 0) begin
				// single entry: inserts past full at both ends must fail
				send(bdq_pkg::CMD_INS_REAR, 32'hCAFE_0001);
				send(bdq_pkg::CMD_INS_FRONT, 32'hCAFE_0002);
				send(bdq_pkg::CMD_INS_REAR, 32'hCAFE_0003);
				send(bdq_pkg::CMD_DEL_FRONT, 32'h0);
				send(bdq_pkg::CMD_DEL_REAR, 32'h0);
				send(bdq_pkg::CMD_INS_FRONT, 32'hCAFE_0004);
			end
			// one whole phase runs back to back with no gaps or stalls
			steady = (p == 5);
			random_phase(PHASE_LEN);
			drain();
			steady = 1'b0;
		end

		// a random register value; the write must drop what is held
		set_capacity(CNT_W'($urandom_range(31)));
		send(bdq_pkg::CMD_PEEK, 32'h0);
		random_phase(PHASE_LEN);
		drain();

		repeat (TAIL_WAIT) @(posedge clk);
		if (n_fail == 0 && view_expected.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

### filelist.f
design/bdq_pkg.sv
design/bdq_if.sv
design/bdq_ctrl.sv
design/bdq_datapath.sv
design/bounded_deque_core.sv
tb/sv/bounded_deque_core_tb.sv
